// File: hdl/sdge_pkg.sv
// shared types, constants and the resistance code table of the scroll gesture encoder
package sdge_pkg;

  localparam int IDLE_BITS_DEF  = 14;
  localparam int COUNT_BITS_DEF = 4;

  localparam int THR_W     = 4;
  localparam int TIMEOUT_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 14;
  localparam int WORD_W    = 16;
  localparam int CODE_W    = 8;
  localparam int STEP_W    = 4;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;

  localparam logic [THR_W-1:0]     THRESHOLD_RST = 4'd3;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 14'd7000;

  localparam logic [WORD_W-1:0] WORD_SHUTDOWN = 16'h9000;
  localparam logic [WORD_W-1:0] WORD_DISABLE  = 16'hA000;
  localparam logic [WORD_W-1:0] WORD_RESET    = 16'hC000;

  localparam logic [STEP_W-1:0] STEP_LEFT  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RIGHT = 4'd4;
  localparam logic [STEP_W-1:0] STEP_UP    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DOWN  = 4'd8;

  localparam logic [STEP_W-1:0] STEP_FULL = 4'd9;
  localparam logic [STEP_W-1:0] STEP_ZERO = 4'd0;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              wide;
  } frame_t;

  // up to three frames produced by one transaction
  typedef struct packed {
    logic [1:0]        count;
    frame_t [2:0]      frames;
  } bundle_t;

  function automatic logic [CODE_W-1:0] res_code(input logic [STEP_W-1:0] step);
    logic [CODE_W-1:0] code;
    unique case (step)
      4'd0:    code = 8'h00;
      4'd1:    code = 8'h1d;
      4'd2:    code = 8'h3a;
      4'd3:    code = 8'h59;
      4'd4:    code = 8'h77;
      4'd5:    code = 8'h94;
      4'd6:    code = 8'hb3;
      4'd7:    code = 8'hcf;
      4'd8:    code = 8'hea;
      4'd9:    code = 8'hff;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic frame_t narrow_frame(input logic [STEP_W-1:0] step);
    frame_t f;
    f.value = {{(WORD_W-CODE_W){1'b0}}, res_code(step)};
    f.wide  = 1'b0;
    return f;
  endfunction

  function automatic frame_t wide_frame(input logic [WORD_W-1:0] word);
    frame_t f;
    f.value = word;
    f.wide  = 1'b1;
    return f;
  endfunction

endpackage

// File: hdl/sdge_core.sv
// gesture state, configuration registers and per-transaction frame generation
module sdge_core #(
  parameter int IDLE_BITS  = sdge_pkg::IDLE_BITS_DEF,
  parameter int COUNT_BITS = sdge_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [sdge_pkg::CMD_W-1:0]     command_i,
  input  logic [3:0]                     lines_i,
  input  logic                           cfg_valid_i,
  input  logic [sdge_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sdge_pkg::CFG_W-1:0]     cfg_data_i,
  output sdge_pkg::bundle_t              bundle_o
);
  import sdge_pkg::*;

  localparam int IDLE_CMP_W = (IDLE_BITS > TIMEOUT_W) ? IDLE_BITS : TIMEOUT_W;
  localparam int CNT_CMP_W  = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  logic [THR_W-1:0]     thr_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  logic                       awake_q, awake_d;
  logic [3:0]                 prev_q, prev_d;
  logic [3:0][COUNT_BITS-1:0] counts_q, counts_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [IDLE_BITS-1:0]       idle_q, idle_d;

  logic [IDLE_BITS-1:0]       idle_inc;
  logic [3:0]                 diff;
  logic [1:0]                 sel;
  logic [3:0][COUNT_BITS-1:0] counts_inc;
  logic [3:0]                 nonzero;
  logic [3:0]                 reached;
  logic [THR_W-1:0]           thr_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THRESHOLD_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_THRESHOLD) begin
        thr_q <= cfg_data_i[THR_W-1:0];
      end else if (cfg_index_i == CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awake_q  <= 1'b0;
      prev_q   <= '0;
      counts_q <= '0;
      step_q   <= '0;
      idle_q   <= '0;
    end else if (accept_i) begin
      awake_q  <= awake_d;
      prev_q   <= prev_d;
      counts_q <= counts_d;
      step_q   <= step_d;
      idle_q   <= idle_d;
    end
  end

  assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign diff     = lines_i ^ prev_q;
  assign thr_eff  = (thr_q == '0) ? THR_W'(1) : thr_q;

  // first changed line wins: left, right, up, down
  always_comb begin
    priority if (diff[0]) sel = 2'd0;
    else if (diff[1])     sel = 2'd1;
    else if (diff[2])     sel = 2'd2;
    else                  sel = 2'd3;
  end

  always_comb begin
    counts_inc = counts_q;
    if (counts_q[sel] != '1) begin
      counts_inc[sel] = counts_q[sel] + 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      nonzero[i] = (counts_inc[i] != '0);
    end
    // conflicting directions wipe everything
    if ($countones(nonzero) > 1) begin
      counts_inc = '0;
    end
    for (int i = 0; i < 4; i++) begin
      reached[i] = CNT_CMP_W'(counts_inc[i]) >= CNT_CMP_W'(thr_eff);
    end
  end

  always_comb begin
    awake_d  = awake_q;
    prev_d   = prev_q;
    counts_d = counts_q;
    step_d   = step_q;
    idle_d   = idle_q;
    bundle_o = '0;
    if (command_i == CMD_WAKE) begin
      awake_d            = 1'b1;
      idle_d             = '0;
      bundle_o.count     = 2'd3;
      bundle_o.frames[0] = wide_frame(WORD_RESET);
      bundle_o.frames[1] = narrow_frame(STEP_FULL);
      bundle_o.frames[2] = narrow_frame(STEP_ZERO);
    end else if (awake_q && command_i == CMD_TICK) begin
      idle_d = idle_inc;
      if (IDLE_CMP_W'(idle_inc) >= IDLE_CMP_W'(timeout_q)) begin
        awake_d            = 1'b0;
        bundle_o.count     = 2'd2;
        bundle_o.frames[0] = wide_frame(WORD_SHUTDOWN);
        bundle_o.frames[1] = wide_frame(WORD_DISABLE);
      end
    end else if (awake_q && command_i == CMD_SAMPLE && diff != '0) begin
      counts_d = counts_inc;
      priority if (reached[0]) begin
        step_d   = STEP_LEFT;
        counts_d = '0;
      end else if (reached[1]) begin
        step_d   = STEP_RIGHT;
        counts_d = '0;
      end else if (reached[2]) begin
        step_d   = STEP_UP;
        counts_d = '0;
      end else if (reached[3]) begin
        step_d   = STEP_DOWN;
        counts_d = '0;
      end
      prev_d             = lines_i;
      idle_d             = '0;
      bundle_o.count     = 2'd2;
      bundle_o.frames[0] = narrow_frame(step_d);
      bundle_o.frames[1] = narrow_frame(STEP_ZERO);
    end
  end

endmodule

// File: hdl/sdge_frame_ser.sv
// result register that holds one transaction's frames and sends them one per cycle while out_ready_i is high
module sdge_frame_ser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  sdge_pkg::bundle_t      bundle_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sdge_pkg::frame_t       frame_o,
  output logic                   last_o
);
  import sdge_pkg::*;

  bundle_t    buf_q;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       done;

  assign out_valid_o = valid_q;
  assign frame_o     = buf_q.frames[idx_q];
  assign last_o      = (idx_q == buf_q.count - 2'd1);
  assign done        = valid_q && out_ready_i && last_o;
  assign free_o      = !valid_q || done;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i && bundle_i.count != '0) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (valid_q && out_ready_i) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && bundle_i.count != '0) begin
      buf_q <= bundle_i;
    end
  end

endmodule

// File: hdl/scroll_direction_gesture_encoder.sv
// top level of the scroll gesture encoder: state update and frame output register
// first frame: registered, valid in the cycle after the input transaction is accepted
// output: frames leave one per cycle while out_ready_i is high (wake 3, step 2, shutdown 2);
//   the single frame output register takes a new transaction once its last frame is accepted
// reset: asynchronous active low; asleep, lines, counters, step and idle count cleared,
//   threshold 3 and timeout 7000
module scroll_direction_gesture_encoder #(
  parameter int IDLE_BITS  = sdge_pkg::IDLE_BITS_DEF,
  parameter int COUNT_BITS = sdge_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sdge_pkg::CMD_W-1:0]     command_i,
  input  logic                           left_line_i,
  input  logic                           right_line_i,
  input  logic                           up_line_i,
  input  logic                           down_line_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdge_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sdge_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sdge_pkg::WORD_W-1:0]    frame_value_o,
  output logic                           frame_wide_o,
  output logic                           last_o
);
  import sdge_pkg::*;

  logic    accept;
  bundle_t bundle;
  frame_t  frame;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  sdge_core #(
    .IDLE_BITS  (IDLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .lines_i     ({down_line_i, up_line_i, right_line_i, left_line_i}),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bundle_o    (bundle)
  );

  sdge_frame_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .free_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_o     (frame),
    .last_o      (last_o)
  );

  assign frame_value_o = frame.value;
  assign frame_wide_o  = frame.wide;

endmodule

// File: hdl/sdge_checker.sv
// port-level checks for the scroll gesture encoder, bound to the top level
module sdge_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [sdge_pkg::CMD_W-1:0]     command_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [sdge_pkg::WORD_W-1:0]    frame_value_o,
  input logic                           frame_wide_o,
  input logic                           last_o
);
  import sdge_pkg::*;

  // a stalled frame must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_value_o)
                                    && $stable(frame_wide_o) && $stable(last_o))
    else $error("stalled frame changed");

  // wake always opens with the wide reset word
  a_wake_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == CMD_WAKE |=>
      out_valid_o && frame_value_o == WORD_RESET && frame_wide_o && !last_o)
    else $error("wake did not start with reset word");

  // an idle output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a transaction's frames come without gaps until the last one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && (last_o || !in_ready_o))
    else $error("frame sequence broken before last");

endmodule

bind scroll_direction_gesture_encoder sdge_checker u_sdge_checker (.*);
